### design/crc8fd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8fd_pkg: shared types, constants and the CRC-8 byte update
// Holds the phase encoding, the result record passed between the parser
// and the output register, and the unrolled CRC-8 (poly 0x1C) byte step.
// ----------------------------------------------------------------------------
package crc8fd_pkg;

	localparam logic [7:0] CRC_POLY  = 8'h1C;
	localparam logic [7:0] SYNC_RST  = 8'h01;
	localparam logic [3:0] HDR_TAG   = 4'h6;
	localparam logic [2:0] HDR_CHECK = 3'd6;
	localparam logic [2:0] HDR_LAST  = 3'd7;
	localparam int         HDR_BYTES = 7;
	localparam int         TDATA_W   = 56;

	typedef enum logic [1:0] {
		PH_HUNT    = 2'd0,
		PH_HEADER  = 2'd1,
		PH_PAYLOAD = 2'd2
	} phase_t;

	typedef struct packed {
		logic        byte_valid;
		logic [7:0]  payload_byte;
		logic        frame_end;
		logic        crc_ok;
		logic [5:0]  msg_type;
		logic [11:0] src_addr;
		logic [11:0] dst_addr;
		logic [1:0]  delivery;
		logic [1:0]  priority_res;
		logic [9:0]  payload_len;
	} res_t;

	// Handshake between the input register and the parser.
	typedef struct packed {
		logic       valid;
		logic [7:0] data;
	} item_t;

	// One CRC-8 byte step, MSB first, eight shift-and-xor steps.
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

endpackage

### design/crc8fd_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8fd_in_stage: input register
// Captures one received byte per transfer and holds it until the parser
// consumes it.
// ----------------------------------------------------------------------------
module crc8fd_in_stage
	import crc8fd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,
	input  logic       consume,
	output item_t      item
);

	logic       valid_s1;
	logic [7:0] byte_s1;

	assign s_axis_tready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	assign item.valid = valid_s1;
	assign item.data  = byte_s1;

endmodule

### design/crc8fd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8fd_parser: frame state machine
// Hunts for the sync byte, collects the header, runs the CRC and forms one
// result per payload byte or per empty frame end.
// ----------------------------------------------------------------------------
module crc8fd_parser
	import crc8fd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  item_t      item,
	output logic       consume,
	input  logic       res_ready,
	output logic       res_load,
	output res_t       res
);

	phase_t      phase_q, phase_n;
	logic [2:0]  idx_q, idx_n;
	logic [55:0] hdr_q, hdr_n;
	logic [7:0]  crc_q, crc_n;
	logic [9:0]  left_q, left_n;
	logic [7:0]  sync_q;
	logic [2:0]  k;
	logic        res_v;
	logic        fire;

	// Header byte k of the frame sits at bits 8*(k-1).
	function automatic res_t fill_end(input logic [55:0] h, input logic [7:0] crc);
		res_t r;
		r              = '0;
		r.frame_end    = 1'b1;
		r.crc_ok       = (crc == h[55:48]);
		r.msg_type     = h[13:8];
		r.src_addr     = {h[23:16], h[31:28]};
		r.dst_addr     = {h[27:24], h[39:32]};
		r.delivery     = h[47:46];
		r.priority_res = h[45:44];
		r.payload_len  = {h[7:0], h[15:14]};
		return r;
	endfunction

	assign k = (idx_q == 3'd7) ? 3'd7 : idx_q + 3'd1;

	always_comb begin
		phase_n = phase_q;
		idx_n   = idx_q;
		hdr_n   = hdr_q;
		crc_n   = crc_q;
		left_n  = left_q;
		res_v   = 1'b0;
		res     = '0;
		case (phase_q)
			PH_HEADER: begin
				if (k == HDR_CHECK && item.data[3:0] != HDR_TAG) begin
					phase_n = PH_HUNT;
					idx_n   = '0;
				end else begin
					for (int i = 0; i < HDR_BYTES; i++) begin
						if (k == 3'(i + 1)) begin
							hdr_n[8*i +: 8] = hdr_q[8*i +: 8] | item.data;
						end
					end
					// The CRC byte itself enters the sum as zero.
					crc_n = crc8_update(crc_q, (k == HDR_LAST) ? 8'h00 : item.data);
					if (k != HDR_LAST) begin
						idx_n = k;
					end else begin
						idx_n  = '0;
						left_n = {hdr_n[7:0], hdr_n[15:14]};
						if (left_n == '0) begin
							res_v   = 1'b1;
							res     = fill_end(hdr_n, crc_n);
							phase_n = PH_HUNT;
						end else begin
							phase_n = PH_PAYLOAD;
						end
					end
				end
			end
			PH_PAYLOAD: begin
				crc_n  = crc8_update(crc_q, item.data);
				left_n = left_q - 10'd1;
				res_v  = 1'b1;
				if (left_n == '0) begin
					res     = fill_end(hdr_q, crc_n);
					phase_n = PH_HUNT;
				end
				res.byte_valid   = 1'b1;
				res.payload_byte = item.data;
			end
			default: begin
				phase_n = PH_HUNT;
				if (item.data == sync_q) begin
					crc_n   = crc8_update(8'h00, item.data);
					idx_n   = '0;
					hdr_n   = '0;
					left_n  = '0;
					phase_n = PH_HEADER;
				end
			end
		endcase
	end

	assign fire     = item.valid && (!res_v || res_ready);
	assign consume  = fire;
	assign res_load = fire && res_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			idx_q   <= '0;
			hdr_q   <= '0;
			crc_q   <= '0;
			left_q  <= '0;
		end else if (fire) begin
			phase_q <= phase_n;
			idx_q   <= idx_n;
			hdr_q   <= hdr_n;
			crc_q   <= crc_n;
			left_q  <= left_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= SYNC_RST;
		end else if (cfg_wr_en) begin
			sync_q <= cfg_wr_data;
		end
	end

`ifndef SYNTHESIS
	a_end_not_hunting: assert property (@(posedge clk) disable iff (!arst_n)
		res_load && res.frame_end |-> phase_q != PH_HUNT)
		else $error("frame end produced while hunting");

	a_plain_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_load && !res.frame_end |-> !res.crc_ok && res.payload_len == '0)
		else $error("header fields set on a non-final result");

	a_payload_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		fire && phase_q == PH_HEADER && phase_n == PH_PAYLOAD |=> left_q != '0)
		else $error("payload phase entered with zero length");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != 3'd7)
		else $error("header index out of range");
`endif

endmodule

### design/crc8fd_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8fd_out_stage: result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module crc8fd_out_stage
	import crc8fd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic res_load,
	input  res_t res,
	output logic res_ready,
	output logic out_valid,
	input  logic out_ready,
	output res_t out_res
);

	logic out_valid_q;
	res_t res_q;

	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_load;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = res_q;

endmodule

### design/crc8_frame_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8_frame_deframer: CRC-8 protected packet deframer
// Path: the byte that causes a result is held in the input register, and the
// result is then registered in the result register before the master side
// sees it.
// Throughput: one byte per cycle unless the master side holds back a result; the CRC-8 byte update is combinational.
// Reset: arst_n is asynchronous, active low; the block returns to hunting,
// the sync byte register returns to 0x01, and no clearing pass is needed.
// ----------------------------------------------------------------------------
// The input register decouples the slave side: a byte can be taken while a
// finished result still waits in the result register. The parser consumes
// the held byte when it produces no result, or when the result register is
// free or being emptied in the same cycle.
//
// A frame is the sync byte, six header bytes and a CRC byte, then the
// payload. Each payload byte becomes one result transfer; the last one, or
// the CRC byte of an empty frame, carries tlast with the header fields and
// the CRC check. A header whose sixth byte lacks the low nibble 6 is dropped
// silently and the block hunts again, starting with the next byte.
module crc8_frame_deframer
	import crc8fd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [7:0]         cfg_wr_data,   // sync_byte
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [7:0]         s_axis_tdata,  // rx_byte
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	// From bit 0: payload_byte[7:0], crc_ok, msg_type[5:0], src_addr[11:0],
	// dst_addr[11:0], delivery[1:0], priority_res[1:0], payload_len[9:0], zero fill.
	output logic [TDATA_W-1:0] m_axis_tdata,
	output logic               m_axis_tuser,  // byte_valid
	output logic               m_axis_tlast   // frame_end
);

	item_t item;
	logic  consume;
	logic  res_ready;
	logic  res_load;
	res_t  res;
	res_t  out_res;

	crc8fd_in_stage u_in (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.consume       (consume),
		.item          (item)
	);

	crc8fd_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.item        (item),
		.consume     (consume),
		.res_ready   (res_ready),
		.res_load    (res_load),
		.res         (res)
	);

	crc8fd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_load  (res_load),
		.res       (res),
		.res_ready (res_ready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	// Pack the result fields into tdata, lowest field first.
	assign m_axis_tdata = {3'b000, out_res.payload_len, out_res.priority_res,
		out_res.delivery, out_res.dst_addr, out_res.src_addr, out_res.msg_type,
		out_res.crc_ok, out_res.payload_byte};
	assign m_axis_tuser = out_res.byte_valid;
	assign m_axis_tlast = out_res.frame_end;

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the CRC-8 frame deframer
// Builds framed byte streams (good frames, corrupted CRC bytes, bad tag bytes
// in header byte 6, loose noise), feeds them through the slave side with
// random gaps and checks every master-side transfer against a cycle-free
// model of the deframer that runs on each accepted input byte.
// ----------------------------------------------------------------------------
module tb_top;
	import crc8fd_pkg::*;

	localparam int HALF_PERIOD = 4;
	localparam int RESET_CYCLES = 12;
	localparam int IDLE_PAD = 6;        // cycles to let the two-stage pipe settle
	localparam int LONG_HOLD = 400;     // one long receiver hold-off
	localparam int MAX_PRINTED = 40;

	typedef enum int {
		FR_GOOD,
		FR_BAD_CRC,
		FR_BAD_TAG
	} frame_kind_t;

	// ------------------------------------------------------------------------
	// Clock, reset and block ports. Every input is known from time zero.
	// ------------------------------------------------------------------------
	logic clk;
	logic arst_n = 1'b0;

	logic               cfg_wr_en = 1'b0;
	logic [7:0]         cfg_wr_data = 8'h00;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [7:0]         s_axis_tdata = 8'h00;
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [TDATA_W-1:0] m_axis_tdata;
	logic               m_axis_tuser;
	logic               m_axis_tlast;

	always begin
		clk = 1'b1;
		#HALF_PERIOD;
		clk = 1'b0;
		#HALF_PERIOD;
	end

	crc8_frame_deframer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// ------------------------------------------------------------------------
	// Bench state. The accepted-byte counter, which the test sequence polls, is
	// advanced with a nonblocking assignment so that its reader sees a stable value.
	// ------------------------------------------------------------------------
	logic [7:0] rx_backlog [$];     // bytes waiting to be offered on the slave side
	logic [7:0] frame_buf [$];      // scratch frame built by build_frame
	res_t       due_results [$];    // predicted master-side transfers, oldest first

	int n_pushed = 0;
	int n_accepted = 0;
	int n_errors = 0;
	int n_results = 0;
	int n_frame_ends = 0;
	int n_crc_fails = 0;
	int n_frames = 0;
	int n_bad_crc = 0;
	int n_bad_tag = 0;
	int n_settings = 0;
	bit calm = 1'b0;                // when set, neither side idles
	int rx_gap = 0;
	int tx_hold = 0;
	bit long_hold_done = 1'b0;

	// Deframer model: phase, header position, collected header bytes 1..7
	// (byte k at bits 8(k-1)), running CRC and payload bytes still to come.
	phase_t      mdl_phase = PH_HUNT;
	int unsigned mdl_hidx = 0;
	logic [55:0] mdl_hdr = '0;
	logic [7:0]  mdl_crc = 8'h00;
	logic [9:0]  mdl_left = '0;
	logic [7:0]  sync_model = SYNC_RST;

	task automatic flag_error(input string msg);
		if (n_errors < MAX_PRINTED)
			$display("ERROR @%0t: %s", $realtime, msg);
		n_errors++;
	endtask

	// CRC-8, MSB first: each message bit is folded into the feedback tap.
	function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] b);
		logic [7:0] c;
		logic fb;
		c = acc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[7] ^ b[i];
			c = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
		end
		return c;
	endfunction

	// Fills the frame-end fields of a result from the collected header.
	function automatic res_t close_frame(input res_t r);
		logic [7:0] h [1:7];
		for (int k = 1; k <= 7; k++)
			h[k] = mdl_hdr[8*(k-1) +: 8];
		r.frame_end = 1'b1;
		r.crc_ok = (mdl_crc == h[7]);
		r.msg_type = h[2][5:0];
		r.src_addr = {h[3], h[4][7:4]};
		r.dst_addr = {h[4][3:0], h[5]};
		r.delivery = h[6][7:6];
		r.priority_res = h[6][5:4];
		r.payload_len = {h[1], h[2][7:6]};
		return r;
	endfunction

	// Advances the model by one accepted byte and queues any result it causes.
	task automatic deframe_byte(input logic [7:0] b);
		res_t r;
		int unsigned k;
		r = '0;
		case (mdl_phase)
			PH_HEADER: begin
				k = mdl_hidx + 1;
				if (k == 32'(HDR_CHECK) && b[3:0] != HDR_TAG) begin
					// A bad tag drops the header; this byte is not a new sync candidate.
					mdl_phase = PH_HUNT;
					mdl_hidx = 0;
				end else begin
					mdl_hdr[8*(k-1) +: 8] = b;
					// The CRC byte itself is counted as zero.
					mdl_crc = crc8_next(mdl_crc, (k == 32'(HDR_LAST)) ? 8'h00 : b);
					if (k < HDR_BYTES) begin
						mdl_hidx = k;
					end else begin
						mdl_hidx = 0;
						mdl_left = {mdl_hdr[7:0], mdl_hdr[15:14]};
						if (mdl_left == '0) begin
							// Empty payload: the CRC byte closes the frame.
							due_results.push_back(close_frame(r));
							mdl_phase = PH_HUNT;
						end else begin
							mdl_phase = PH_PAYLOAD;
						end
					end
				end
			end
			PH_PAYLOAD: begin
				mdl_crc = crc8_next(mdl_crc, b);
				mdl_left = mdl_left - 10'd1;
				r.byte_valid = 1'b1;
				r.payload_byte = b;
				if (mdl_left == '0) begin
					r = close_frame(r);
					mdl_phase = PH_HUNT;
				end
				due_results.push_back(r);
			end
			default: begin
				mdl_phase = PH_HUNT;
				if (b == sync_model) begin
					mdl_crc = crc8_next(8'h00, b);
					mdl_hidx = 0;
					mdl_hdr = '0;
					mdl_left = '0;
					mdl_phase = PH_HEADER;
				end
			end
		endcase
	endtask

	// Idle length for either side: mostly none, often short, sometimes long.
	function automatic int pick_idle();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// ------------------------------------------------------------------------
	// Slave-side driver. A transfer completes at an edge where tvalid and
	// tready were both high; the model is stepped with that byte, then the
	// next byte (or a gap) is put up.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				deframe_byte(s_axis_tdata);
				n_accepted <= n_accepted + 1;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (rx_gap > 0) begin
					rx_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (rx_backlog.size() > 0) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= rx_backlog.pop_front();
					rx_gap = pick_idle();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Master-side monitor. Each result transfer is unpacked from tdata/tuser/
	// tlast and compared field by field with the oldest prediction.
	// ------------------------------------------------------------------------
	task automatic cmp_field(input string name, input int unsigned got, input int unsigned want);
		if (got != want)
			flag_error($sformatf("result %0d: %s is 0x%0h, expected 0x%0h",
				n_results, name, got, want));
	endtask

	task automatic check_result();
		res_t got, want;
		got.byte_valid = m_axis_tuser;
		got.payload_byte = m_axis_tdata[7:0];
		got.frame_end = m_axis_tlast;
		got.crc_ok = m_axis_tdata[8];
		got.msg_type = m_axis_tdata[14:9];
		got.src_addr = m_axis_tdata[26:15];
		got.dst_addr = m_axis_tdata[38:27];
		got.delivery = m_axis_tdata[40:39];
		got.priority_res = m_axis_tdata[42:41];
		got.payload_len = m_axis_tdata[52:43];
		if ($isunknown({m_axis_tdata, m_axis_tuser, m_axis_tlast}))
			flag_error($sformatf("result %0d carries unknown bits", n_results));
		if (m_axis_tdata[TDATA_W-1:53] != '0)
			flag_error($sformatf("result %0d: fill bits of tdata are not zero", n_results));
		if (due_results.size() == 0) begin
			flag_error("result transfer with no prediction pending");
		end else begin
			want = due_results.pop_front();
			cmp_field("byte_valid", 32'(got.byte_valid), 32'(want.byte_valid));
			cmp_field("payload_byte", 32'(got.payload_byte), 32'(want.payload_byte));
			cmp_field("frame_end", 32'(got.frame_end), 32'(want.frame_end));
			cmp_field("crc_ok", 32'(got.crc_ok), 32'(want.crc_ok));
			cmp_field("msg_type", 32'(got.msg_type), 32'(want.msg_type));
			cmp_field("src_addr", 32'(got.src_addr), 32'(want.src_addr));
			cmp_field("dst_addr", 32'(got.dst_addr), 32'(want.dst_addr));
			cmp_field("delivery", 32'(got.delivery), 32'(want.delivery));
			cmp_field("priority_res", 32'(got.priority_res), 32'(want.priority_res));
			cmp_field("payload_len", 32'(got.payload_len), 32'(want.payload_len));
			if (want.frame_end) begin
				n_frame_ends++;
				if (!want.crc_ok)
					n_crc_fails++;
			end
		end
		n_results++;
	endtask

	// tready is stalled at random; once, while the long frame is queued, it is
	// held low for a long stretch so that the block fills and stalls its input.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				check_result();
			if (tx_hold > 0) begin
				tx_hold--;
				m_axis_tready <= 1'b0;
			end else if (!long_hold_done && rx_backlog.size() > 200) begin
				long_hold_done = 1'b1;
				tx_hold = LONG_HOLD - 1;
				m_axis_tready <= 1'b0;
			end else begin
				tx_hold = pick_idle();
				if (tx_hold > 0) begin
					tx_hold--;
					m_axis_tready <= 1'b0;
				end else begin
					m_axis_tready <= 1'b1;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers.
	// ------------------------------------------------------------------------
	task automatic push_byte(input logic [7:0] b);
		rx_backlog.push_back(b);
		n_pushed++;
	endtask

	// Builds one frame in frame_buf with the current sync byte. A bad-tag
	// frame stops at header byte 6; with tag_is_sync that byte repeats the
	// sync byte when the sync byte itself has a wrong low nibble.
	task automatic build_frame(input frame_kind_t kind, input logic [9:0] len,
			input logic [5:0] msg, input logic [11:0] src, input logic [11:0] dst,
			input logic [1:0] dlv, input logic [1:0] prio, input bit tag_is_sync);
		logic [7:0] tag;
		logic [7:0] acc;
		logic [7:0] body [$];
		int unsigned nib;
		frame_buf.delete();
		frame_buf.push_back(sync_model);
		frame_buf.push_back(len[9:2]);
		frame_buf.push_back({len[1:0], msg});
		frame_buf.push_back(src[11:4]);
		frame_buf.push_back({src[3:0], dst[11:8]});
		frame_buf.push_back(dst[7:0]);
		tag = {dlv, prio, HDR_TAG};
		n_frames++;
		if (kind == FR_BAD_TAG) begin
			n_bad_tag++;
			if (tag_is_sync && sync_model[3:0] != HDR_TAG) begin
				tag = sync_model;
			end else begin
				nib = $urandom_range(0, 14);
				if (nib >= HDR_TAG)
					nib++;
				tag[3:0] = nib[3:0];
			end
			frame_buf.push_back(tag);
			return;
		end
		frame_buf.push_back(tag);
		for (int i = 0; i < len; i++)
			body.push_back(8'($urandom_range(0, 255)));
		acc = 8'h00;
		foreach (frame_buf[i])
			acc = crc8_next(acc, frame_buf[i]);
		acc = crc8_next(acc, 8'h00);
		foreach (body[i])
			acc = crc8_next(acc, body[i]);
		if (kind == FR_BAD_CRC) begin
			acc = acc ^ 8'($urandom_range(1, 255));
			n_bad_crc++;
		end
		frame_buf.push_back(acc);
		foreach (body[i])
			frame_buf.push_back(body[i]);
	endtask

	task automatic push_frame_buf();
		foreach (frame_buf[i])
			push_byte(frame_buf[i]);
	endtask

	// Mostly well-formed frames with random fields and short payloads, mixed
	// with corrupted CRC bytes, bad tag bytes and loose noise between frames.
	task automatic random_traffic(input int n_target);
		int n_frame_bytes;
		int unsigned r;
		logic [9:0] len;
		frame_kind_t kind;
		n_frame_bytes = 0;
		while (n_frame_bytes < n_target) begin
			r = $urandom_range(0, 99);
			if (r >= 88) begin
				repeat ($urandom_range(1, 6))
					push_byte(8'($urandom_range(0, 255)));
			end else begin
				kind = (r < 65) ? FR_GOOD : (r < 77) ? FR_BAD_CRC : FR_BAD_TAG;
				len = ($urandom_range(0, 9) < 8) ? 10'($urandom_range(0, 12)) :
					10'($urandom_range(13, 60));
				build_frame(kind, len, 6'($urandom_range(0, 63)), 12'($urandom_range(0, 4095)),
					12'($urandom_range(0, 4095)), 2'($urandom_range(0, 3)),
					2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
				push_frame_buf();
				n_frame_bytes += frame_buf.size();
			end
		end
	endtask

	// Returns once every queued byte was taken and every predicted result
	// came out, then waits out the IDLE_PAD settle time for a byte that causes no result.
	task automatic wait_idle();
		while (n_accepted != n_pushed || due_results.size() != 0)
			@(posedge clk);
		repeat (IDLE_PAD)
			@(posedge clk);
	endtask

	task automatic write_sync(input logic [7:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sync_model = value;
		n_settings++;
	endtask

	// ------------------------------------------------------------------------
	// Test sequence.
	// ------------------------------------------------------------------------
	initial begin
		logic [7:0] sync_plan [6];
		sync_plan = '{8'h00, 8'hFF, 8'hA6, 8'h00, 8'h01, 8'h00};
		sync_plan[3] = 8'($urandom_range(0, 255));
		sync_plan[5] = 8'($urandom_range(0, 255));

		repeat (RESET_CYCLES)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Directed, with the reset sync byte: an empty frame with every header
		// field at its maximum, a header dropped on a bad tag byte that equals
		// the sync byte, then a one-byte frame with zero fields and a bad CRC.
		build_frame(FR_GOOD, 10'd0, 6'h3F, 12'hFFF, 12'hFFF, 2'd3, 2'd3, 1'b0);
		push_frame_buf();
		build_frame(FR_BAD_TAG, 10'd0, 6'h00, 12'h000, 12'h000, 2'd0, 2'd0, 1'b1);
		push_frame_buf();
		build_frame(FR_BAD_CRC, 10'd1, 6'h00, 12'h000, 12'h000, 2'd0, 2'd0, 1'b0);
		push_frame_buf();
		wait_idle();

		// Sync byte changed in the middle of a header: the open frame must
		// still complete, and the new value applies from the next hunt on.
		build_frame(FR_GOOD, 10'd3, 6'($urandom_range(0, 63)), 12'($urandom_range(0, 4095)),
			12'($urandom_range(0, 4095)), 2'($urandom_range(0, 3)),
			2'($urandom_range(0, 3)), 1'b0);
		for (int i = 0; i < 4; i++)
			push_byte(frame_buf[i]);
		wait_idle();
		write_sync(8'h5A);
		for (int i = 4; i < frame_buf.size(); i++)
			push_byte(frame_buf[i]);
		wait_idle();

		// Random phases under several sync settings. The sender pauses at each
		// boundary until all results are out; one phase runs with no idling,
		// and one opens with a long frame that backs up during the long hold-off.
		foreach (sync_plan[p]) begin
			write_sync(sync_plan[p]);
			calm = (p == 1);
			if (p == 2) begin
				build_frame(FR_GOOD, 10'd300, 6'($urandom_range(0, 63)),
					12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
					2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), 1'b0);
				push_frame_buf();
			end
			random_traffic(75);
			wait_idle();
		end
		calm = 1'b0;

		$display("Sent %0d bytes in %0d frames (%0d bad CRC, %0d bad tag), %0d sync values.",
			n_pushed, n_frames, n_bad_crc, n_bad_tag, n_settings);
		$display("Checked %0d result transfers, %0d frame ends, %0d with a failed CRC.",
			n_results, n_frame_ends, n_crc_fails);
		if (n_errors == 0 && due_results.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Watchdog, far above the slowest correct run.
	initial begin
		#5_000_000;
		$display("Timeout with %0d results still predicted.", due_results.size());
		$display("simulation failed");
		$finish;
	end

endmodule

### crc8_frame_deframer.f
design/crc8fd_pkg.sv
design/crc8fd_in_stage.sv
design/crc8fd_parser.sv
design/crc8fd_out_stage.sv
design/crc8_frame_deframer.sv
tb/sv/tb_top.sv
